### sv/assert_macros.svh
// Assertion helpers for the packed sample decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### sv/p20f_pkg.sv
package p20f_pkg;
    typedef struct packed {
        logic [15:0] word;
        logic        trace_start;
    } t_in;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic [1:0]  channel;
        logic        group_last;
    } t_out;

    typedef struct packed {
        logic [15:0] mag;
        logic        neg;
        logic [3:0]  expo;
        logic [1:0]  channel;
    } t_job;

    localparam int unsigned LastPos = 4;
endpackage

### sv/p20f_front.sv
module p20f_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  p20f_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output p20f_pkg::t_job  o_job
);
    import p20f_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_expw, n_expw;
    logic        r_valid, n_valid;
    t_job        r_job, n_job;
    logic        take, is_exp;
    logic [16:0] sfrac;
    logic [1:0]  ch;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign is_exp  = i_data.trace_start || r_pos == 3'd0 || r_pos > 3'(LastPos);
    assign ch      = 2'(r_pos - 3'd1);

    always_comb begin
        n_pos   = r_pos;
        n_expw  = r_expw;
        n_valid = r_valid && i_stall;
        n_job   = r_job;
        sfrac   = {i_data.word[15], i_data.word} + 17'(i_data.word[15]);
        if (take) begin
            if (is_exp) begin
                n_expw = i_data.word;
                n_pos  = 3'd1;
            end else begin
                n_valid     = 1'b1;
                n_job.neg   = sfrac[16];
                n_job.mag   = sfrac[16] ? 16'(-sfrac) : sfrac[15:0];
                n_job.expo  = 4'(r_expw >> (4'd12 - {ch, 2'b00}));
                n_job.channel = ch;
                n_pos = (ch == 2'd3) ? 3'd0 : r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_expw  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_expw  <= n_expw;
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule

### sv/p20f_back.sv
module p20f_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  p20f_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_stall,
    output p20f_pkg::t_out  o_data
);
    import p20f_pkg::*;

    logic        r_valid;
    t_out        r_out, n_out;
    logic [3:0]  top;
    logic [15:0] shifted;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        top = '0;
        for (int i = 1; i < 16; i++) begin
            if (i_job.mag[i]) top = 4'(i);
        end
        shifted = i_job.mag << (4'd15 - top);
        n_out.channel    = i_job.channel;
        n_out.group_last = i_job.channel == 2'd3;
        if (i_job.mag == '0) begin
            n_out.sample_bits = '0;
        end else begin
            n_out.sample_bits = {i_job.neg, 8'(8'd112 + {4'd0, top} + {4'd0, i_job.expo}),
                                 shifted[14:0], 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;
endmodule

### sv/packed_20bit_to_float.sv
// Packed 20-bit sample decoder.
// The input channel takes one 16-bit word per request with a trace-start
// flag. Words form groups of five: an exponent word, then four fractions.
// The exponent word produces no output; each fraction produces one request
// on the output channel with IEEE single bits, its channel and a group-last
// flag. A trace start makes its word the exponent word of a new group.
// Throughput is one word per cycle while the input stall is low. A
// fraction passes through the front stage, which selects the exponent
// and takes the magnitude, and then the back stage, which normalizes
// and packs the result.
// When the receiver stalls, the back stage holds its result, then the
// front stage fills, and then the input stall rises.
// Reset clears both stages and the group position, so the next word is
// taken as an exponent word.
`include "assert_macros.svh"
module packed_20bit_to_float (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  p20f_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output p20f_pkg::t_out o_data
);
    import p20f_pkg::*;

    logic mid_valid, mid_stall;
    t_job mid_job;

    p20f_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid(mid_valid), .i_stall(mid_stall), .o_job(mid_job)
    );

    p20f_back u_back (
        .i_clk, .i_rst_n, .i_valid(mid_valid), .o_stall(mid_stall), .i_job(mid_job),
        .o_valid, .i_stall, .o_data
    );

    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_data))
    `ASSERT_CLK(a_stall, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)
    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid && !o_stall)
endmodule
